// ===== sv/ifrp_pkg.sv =====
// Shared constants and types for the IMU frame resync parser.
// Used by the front end, the frame queue, the back end and the top level.
package ifrp_pkg;

  localparam int unsigned FrameLen  = 11;
  localparam int unsigned SumLen    = 10;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FillW     = $clog2(SumLen + 1);
  localparam int unsigned WinIdxW   = $clog2(SumLen);
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeGyro   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  localparam logic [1:0] KindAccel = 2'd0;
  localparam logic [1:0] KindGyro  = 2'd1;
  localparam logic [1:0] KindAngle = 2'd2;
  localparam logic [1:0] KindOther = 2'd3;

  // A checked frame as it travels from the front end to the back end.
  // data holds frame bytes 2..9, byte 2 in the low eight bits.
  typedef struct packed {
    logic [7:0]  type_byte;
    logic [63:0] data;
  } frame_t;

endpackage

// ===== sv/ifrp_front.sv =====
// Front end: keeps the byte window, a running sum, and checks each full window.
// Depends on ifrp_pkg.
module ifrp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       byte_in,
  output logic             frm_valid,
  output ifrp_pkg::frame_t frm
);
  import ifrp_pkg::*;

  logic [7:0]       win_r [SumLen];
  logic [FillW-1:0] fill_r;
  logic [FillW-1:0] fill_nxt;
  logic [7:0]       sum_r;
  logic [7:0]       sum_nxt;
  logic             win_full;
  logic             hit;

  // sum_r always holds the 8-bit sum of the stored bytes, so the checksum
  // test needs only one compare against the incoming eleventh byte.
  assign win_full  = (fill_r == FillW'(SumLen));
  assign hit       = win_full && (win_r[0] == HeaderByte) && (sum_r == byte_in);
  assign frm_valid = byte_valid && hit;

  always_comb begin
    frm.type_byte = win_r[1];
    for (int k = 0; k < SumLen - 2; k++) begin
      frm.data[8*k +: 8] = win_r[k+2];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (byte_valid) begin
      if (!win_full) begin
        fill_nxt = fill_r + FillW'(1);
        sum_nxt  = sum_r + byte_in;
      end else if (hit) begin
        fill_nxt = '0;
        sum_nxt  = '0;
      end else begin
        sum_nxt = sum_r - win_r[0] + byte_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid) begin
      if (!win_full) begin
        win_r[fill_r[WinIdxW-1:0]] <= byte_in;
      end else if (!hit) begin
        for (int k = 0; k < SumLen - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[SumLen-1] <= byte_in;
      end
    end
  end

endmodule

// ===== sv/ifrp_fifo.sv =====
// Short queue of checked frames between the front end and the back end.
// Depends on ifrp_pkg.
module ifrp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ifrp_pkg::frame_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output ifrp_pkg::frame_t rd_data,
  output logic             empty
);
  import ifrp_pkg::*;

  frame_t              mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r;
  logic [FifoPtrW-1:0] rd_ptr_r;
  logic [FifoCntW-1:0] cnt_r;
  logic                do_wr;
  logic                do_rd;

  assign full    = (cnt_r == FifoCntW'(FifoDepth));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + FifoPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + FifoPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + FifoCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/ifrp_back.sv =====
// Back end: decodes the frame kind, splits the words and holds the result register.
// Depends on ifrp_pkg.
module ifrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  ifrp_pkg::frame_t q_frm,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       out_frame_kind,
  output logic [7:0]       out_type_byte,
  output logic [15:0]      out_value_a,
  output logic [15:0]      out_value_b,
  output logic [15:0]      out_value_c,
  output logic [15:0]      out_value_d
);
  import ifrp_pkg::*;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [1:0]  kind_nxt;
  logic [7:0]  type_r;
  logic [63:0] data_r;

  // The result register reloads from a non-empty queue when empty or being taken.
  assign q_pop = !q_empty && (!out_valid_r || pop);
  assign empty = !out_valid_r;

  always_comb begin
    unique case (q_frm.type_byte)
      TypeAccel: kind_nxt = KindAccel;
      TypeGyro:  kind_nxt = KindGyro;
      TypeAngle: kind_nxt = KindAngle;
      default:   kind_nxt = KindOther;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= kind_nxt;
      type_r <= q_frm.type_byte;
      data_r <= q_frm.data;
    end
  end

  assign out_frame_kind = kind_r;
  assign out_type_byte  = type_r;
  assign out_value_a    = data_r[15:0];
  assign out_value_b    = data_r[31:16];
  assign out_value_c    = data_r[47:32];
  assign out_value_d    = data_r[63:48];

endmodule

// ===== sv/imu_frame_resync_parser.sv =====
// Top level of the IMU frame resync parser: front end, frame queue, back end.
// Depends on ifrp_pkg, ifrp_front, ifrp_fifo and ifrp_back.
//
// The parser takes one byte per clock cycle while full is low and hunts for
// 11-byte frames that start with 0x55 and end in an 8-bit additive checksum;
// on a miss it slides by one byte. The checksum test is a single compare
// against a running window sum, so every byte is handled in the cycle it
// arrives. A checked frame enters a four-deep queue, then the result register
// that drives the result ports. full rises only when the queue holds four
// frames and the result register is also occupied, so a reader that pops at
// the frame rate never stalls the byte stream.
module imu_frame_resync_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_type_byte,
  output logic [15:0] out_value_a,
  output logic [15:0] out_value_b,
  output logic [15:0] out_value_c,
  output logic [15:0] out_value_d
);
  import ifrp_pkg::*;

  logic   byte_acc;
  logic   frm_valid;
  frame_t frm;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  frame_t q_frm;

  assign full     = q_full;
  assign byte_acc = push && !q_full;

  ifrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_acc),
    .byte_in    (in_rx_byte),
    .frm_valid  (frm_valid),
    .frm        (frm)
  );

  ifrp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (frm_valid),
    .wr_data (frm),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_frm),
    .empty   (q_empty)
  );

  ifrp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_frm          (q_frm),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_frame_kind (out_frame_kind),
    .out_type_byte  (out_type_byte),
    .out_value_a    (out_value_a),
    .out_value_b    (out_value_b),
    .out_value_c    (out_value_c),
    .out_value_d    (out_value_d)
  );

endmodule

// ===== verif/imu_frame_resync_parser_test.sv =====
// Self-checking testbench for imu_frame_resync_parser: a byte stream of good,
// corrupted and truncated frames mixed with noise, checked frame by frame.
// Depends on ifrp_pkg and the RTL of the parser.
module imu_frame_resync_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ifrp_pkg::*;

  localparam int unsigned ByteTarget = 1850;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  type_byte;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic [15:0] value_d;
  } parsed_frame_t;

  // Tracks the byte window the way the parser should and keeps the frames
  // it must produce, oldest first.
  class frame_checker;
    logic [7:0]    window [FrameLen];
    int unsigned   fill;
    parsed_frame_t pending_frames[$];
    int unsigned   errors;
    int unsigned   frames_checked;

    function new();
      fill = 0;
      errors = 0;
      frames_checked = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function logic [1:0] kind_of(logic [7:0] t);
      if (t == TypeAccel) return KindAccel;
      if (t == TypeGyro) return KindGyro;
      if (t == TypeAngle) return KindAngle;
      return KindOther;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]    sum;
      parsed_frame_t f;
      if (fill >= FrameLen) fill = FrameLen - 1;
      window[fill] = b;
      fill++;
      if (fill < FrameLen) return;
      sum = '0;
      for (int k = 0; k < SumLen; k++) sum = sum + window[k];
      if (window[0] != HeaderByte || sum != window[SumLen]) begin
        // Slide the search forward by one byte.
        for (int k = 0; k < FrameLen - 1; k++) window[k] = window[k + 1];
        fill = FrameLen - 1;
        return;
      end
      f.kind      = kind_of(window[1]);
      f.type_byte = window[1];
      f.value_a   = {window[3], window[2]};
      f.value_b   = {window[5], window[4]};
      f.value_c   = {window[7], window[6]};
      f.value_d   = {window[9], window[8]};
      pending_frames.push_back(f);
      fill = 0;
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_frame(parsed_frame_t got);
      parsed_frame_t exp_f;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_f = pending_frames.pop_front();
      compare_field("frame_kind", 16'(exp_f.kind), 16'(got.kind));
      compare_field("type_byte", 16'(exp_f.type_byte), 16'(got.type_byte));
      compare_field("value_a", exp_f.value_a, got.value_a);
      compare_field("value_b", exp_f.value_b, got.value_b);
      compare_field("value_c", exp_f.value_c, got.value_c);
      compare_field("value_d", exp_f.value_d, got.value_d);
      frames_checked++;
    endfunction

    function void check_drained();
      if (pending_frames.size() != 0) begin
        $display("%0t: %0d frames never came out, expected %h, actual none", $time,
                 pending_frames.size(), pending_frames[0]);
        errors += pending_frames.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic [1:0]  out_frame_kind;
  logic [7:0]  out_type_byte;
  logic [15:0] out_value_a;
  logic [15:0] out_value_b;
  logic [15:0] out_value_c;
  logic [15:0] out_value_d;

  frame_checker checker_h = new();
  int unsigned  bytes_sent;
  int unsigned  burst_left;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  int unsigned  read_phase = 0;

  imu_frame_resync_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_frame_kind (out_frame_kind),
    .out_type_byte  (out_type_byte),
    .out_value_a    (out_value_a),
    .out_value_b    (out_value_b),
    .out_value_c    (out_value_c),
    .out_value_d    (out_value_d)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each popped frame, then choose the next pop. The stall
  // pattern cycles through free running, random, short holds and long holds.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      checker_h.check_frame({out_frame_kind, out_type_byte, out_value_a,
                             out_value_b, out_value_c, out_value_d});
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      read_phase++;
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        case ((read_phase / 512) % 4)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          2: begin
            pop <= 1'b1;
            stall_left = $urandom_range(0, 6);
          end
          default: begin
            pop <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
          end
        endcase
      end
    end
  end

  // Presents one byte and holds it until the parser takes it. The sender
  // runs in bursts with idle gaps placed without regard to frame boundaries.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    checker_h.note_byte(b);
    bytes_sent++;
  endtask

  // Sends the first keep bytes of a frame; a nonzero spoil breaks its checksum.
  task automatic send_frame(input logic [7:0] type_code, input logic [15:0] va,
                            input logic [15:0] vb, input logic [15:0] vc,
                            input logic [15:0] vd, input logic [7:0] spoil,
                            input int unsigned keep);
    logic [7:0] frame_bytes [FrameLen];
    logic [7:0] sum;
    frame_bytes[0] = HeaderByte;
    frame_bytes[1] = type_code;
    {frame_bytes[3], frame_bytes[2]} = va;
    {frame_bytes[5], frame_bytes[4]} = vb;
    {frame_bytes[7], frame_bytes[6]} = vc;
    {frame_bytes[9], frame_bytes[8]} = vd;
    sum = '0;
    for (int k = 0; k < SumLen; k++) sum = sum + frame_bytes[k];
    frame_bytes[SumLen] = sum + spoil;
    for (int k = 0; k < keep; k++) send_byte(frame_bytes[k]);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h5555;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 5))
      0: return TypeAccel;
      1: return TypeGyro;
      2: return TypeAngle;
      3: return HeaderByte;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned choice;
    rst_n = 1'b0;
    push = 1'b0;
    in_rx_byte = '0;
    bytes_sent = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a byte with a bad header, a stray header ahead of a real frame,
    // extreme values, and a frame of another type full of header bytes.
    send_byte(8'h00);
    send_byte(HeaderByte);
    send_frame(TypeAccel, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 8'h00, FrameLen);
    send_frame(8'hAA, 16'h5555, 16'h0155, 16'h5500, 16'h5555, 8'h00, FrameLen);

    // Random: mostly good frames, with broken checksums, cut frames and noise.
    while (bytes_sent < ByteTarget) begin
      choice = $urandom_range(0, 99);
      if (choice < 65) begin
        send_frame(pick_type(), pick_value(), pick_value(), pick_value(), pick_value(),
                   8'h00, FrameLen);
      end else if (choice < 78) begin
        send_frame(pick_type(), pick_value(), pick_value(), pick_value(), pick_value(),
                   8'($urandom_range(1, 255)), FrameLen);
      end else if (choice < 88) begin
        send_frame(pick_type(), pick_value(), pick_value(), pick_value(), pick_value(),
                   8'h00, $urandom_range(1, FrameLen - 1));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 2) == 0) ? HeaderByte : 8'($urandom));
        end
      end
    end
    push <= 1'b0;

    while (checker_h.pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    checker_h.check_drained();

    $display("Sent %0d bytes of frames, broken frames and noise; checked %0d frames.",
             bytes_sent, checker_h.frames_checked);
    if (checker_h.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
